FILE: sv/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package ffba_pkg;

	// request kinds
	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

	// map word: blocks held per memory row
	localparam int WORD_BITS = 8;
	localparam int WORD_LSB  = 3;

	// byte offsets and byte counts before division by the block size
	localparam int OFF_W = 17;

	typedef enum logic [1:0] {
		OUT_GRANT = 2'd0,
		OUT_DONE  = 2'd1,
		OUT_FAIL  = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic      cap;
		logic      mul;
		logic      scan_start;
		logic      scan_step;
		logic      mark_step;
		logic      free_start;
		logic      free_step;
		logic      clr_step;
		logic      calc;
		logic      out_load;
		out_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic alloc_bad;
		logic free_bad;
		logic free_past;
		logic found;
		logic scan_end;
		logic mark_last;
		logic free_done;
		logic clr_last;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/ffba_ctrl.sv
// Sequencer of the allocator: steps each request through its phases.
// Depends on ffba_pkg; drives the datapath by command, reads its status.
`default_nettype none

module ffba_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         func,
	input  wire ffba_pkg::status_t  st,
	output logic                    in_ready,
	output ffba_pkg::cmd_t          cmd
);

	typedef enum logic [9:0] {
		ST_INIT = 10'b00_0000_0001,
		ST_IDLE = 10'b00_0000_0010,
		ST_MUL  = 10'b00_0000_0100,
		ST_CHK  = 10'b00_0000_1000,
		ST_SCAN = 10'b00_0001_0000,
		ST_MARK = 10'b00_0010_0000,
		ST_ADDR = 10'b00_0100_0000,
		ST_FREE = 10'b00_1000_0000,
		ST_CLR  = 10'b01_0000_0000,
		ST_RESP = 10'b10_0000_0000
	} state_t;

	state_t               state_q, state_d;
	logic                 alloc_q, alloc_d;
	ffba_pkg::out_kind_t  kind_q, kind_d;

	always_comb begin
		state_d      = state_q;
		alloc_d      = alloc_q;
		kind_d       = kind_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.out_kind = kind_q;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (func)
						ffba_pkg::FUNC_ALLOC: begin
							alloc_d = 1'b1;
							state_d = ST_MUL;
						end
						ffba_pkg::FUNC_FREE: begin
							alloc_d = 1'b0;
							state_d = ST_MUL;
						end
						ffba_pkg::FUNC_CLEAR: state_d = ST_CLR;
						default: begin
							kind_d  = ffba_pkg::OUT_FAIL;
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (alloc_q) begin
					if (st.alloc_bad) begin
						kind_d  = ffba_pkg::OUT_FAIL;
						state_d = ST_RESP;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end else if (st.free_bad) begin
					kind_d  = ffba_pkg::OUT_FAIL;
					state_d = ST_RESP;
				end else if (st.free_past) begin
					kind_d  = ffba_pkg::OUT_DONE;
					state_d = ST_RESP;
				end else begin
					cmd.free_start = 1'b1;
					state_d        = ST_FREE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.found) begin
					state_d = ST_MARK;
				end else if (st.scan_end) begin
					kind_d  = ffba_pkg::OUT_FAIL;
					state_d = ST_RESP;
				end
			end
			ST_MARK: begin
				cmd.mark_step = 1'b1;
				if (st.mark_last) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.calc = 1'b1;
				kind_d   = ffba_pkg::OUT_GRANT;
				state_d  = ST_RESP;
			end
			ST_FREE: begin
				cmd.free_step = 1'b1;
				if (st.free_done) begin
					kind_d  = ffba_pkg::OUT_DONE;
					state_d = ST_RESP;
				end
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					kind_d  = ffba_pkg::OUT_DONE;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// hold until the output register has room
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			alloc_q <= 1'b0;
			kind_q  <= ffba_pkg::OUT_FAIL;
		end else begin
			state_q <= state_d;
			alloc_q <= alloc_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/ffba_dp.sv
// Datapath of the allocator: base register, block-size divider, used-map
// memory with its row walker, and the result register.
// Depends on ffba_pkg and ffba_ram; controlled by ffba_ctrl.
`default_nettype none

module ffba_dp #(
	parameter int BLOCK_BYTES = 16,
	parameter int HEAP_BYTES  = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [1:0]         func,
	input  wire logic [15:0]        req_bytes,
	input  wire logic [31:0]        free_address,
	input  wire ffba_pkg::cmd_t     cmd,
	output ffba_pkg::status_t       st,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             granted_address,
	output logic                    status
);

	localparam int N_BLOCKS    = HEAP_BYTES / BLOCK_BYTES;
	localparam int WB          = ffba_pkg::WORD_BITS;
	localparam int LSB         = ffba_pkg::WORD_LSB;
	localparam int ROWS        = (N_BLOCKS == 0) ? 1 : (N_BLOCKS + WB - 1) / WB;
	localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W       = ROW_W + LSB;
	localparam int CNT_W       = (N_BLOCKS > 0) ? $clog2(N_BLOCKS + 1) : 1;
	localparam int OFF_W       = ffba_pkg::OFF_W;
	// divide by the block size as multiply by a rounded-up reciprocal
	localparam int DIV_SH      = OFF_W + $clog2(BLOCK_BYTES);
	localparam int RECIP_W     = OFF_W + 1;
	localparam int PROD_W      = OFF_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) / BLOCK_BYTES) + 1);
	localparam logic [OFF_W-1:0] COUNT_OFF = OFF_W'(N_BLOCKS);
	localparam logic [IDX_W:0]   COUNT_IDX = (IDX_W + 1)'(N_BLOCKS);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ROW_W:0]   ROW_END   = (ROW_W + 1)'(ROWS);

	logic [31:0]        heap_base_q;
	logic [OFF_W-1:0]   dividend_q;
	logic               bad_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CNT_W-1:0]   need_q;
	logic [CNT_W-1:0]   run_q;
	logic [IDX_W-1:0]   start_q;
	logic [IDX_W-1:0]   end_q;
	logic               first_q;
	logic [ROW_W:0]     rd_row_q;
	logic [ROW_W-1:0]   row_s1;
	logic               pv_s1;
	logic [31:0]        addr_prod_q;
	logic               out_valid_q;
	logic [31:0]        out_addr_q;
	logic               out_status_q;

	logic [OFF_W-1:0]   bytes_ext, alloc_div, free_off, quot;
	logic [32:0]        heap_top;
	logic               addr_bad;
	logic               step_any, rd_issue;
	logic [WB-1:0]      rd_data, inr;
	logic [CNT_W-1:0]   run_next;
	logic               hit;
	logic [LSB-1:0]     hit_bit;
	logic [IDX_W-1:0]   end_idx, start_idx;
	logic [IDX_W:0]     start_full;
	logic [WB-1:0]      mark_wdata, free_wdata;
	logic               free_go, free_cont;
	logic               wr_en;
	logic [ROW_W-1:0]   wr_addr;
	logic [WB-1:0]      wr_data;

	// request decode at accept time
	assign bytes_ext = {1'b0, req_bytes};
	assign alloc_div = bytes_ext + OFF_W'(BLOCK_BYTES - 1);
	assign heap_top  = {1'b0, heap_base_q} + 33'(HEAP_BYTES);
	assign addr_bad  = (free_address == 32'd0) || (free_address < heap_base_q)
		|| ({1'b0, free_address} >= heap_top);
	assign free_off  = OFF_W'(free_address - heap_base_q);
	assign quot      = OFF_W'(prod_q >> DIV_SH);

	assign step_any  = cmd.scan_step || cmd.mark_step || cmd.free_step;
	assign rd_issue  = step_any && (rd_row_q < ROW_END);

	ffba_ram #(
		.WIDTH (WB),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_issue),
		.raddr (rd_row_q[ROW_W-1:0]),
		.rdata (rd_data)
	);

	// blocks past the end of the heap count as used and stop a free
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			inr[j] = {1'b0, row_s1, LSB'(j)} < COUNT_IDX;
		end
	end

	// first-fit step over one map row
	always_comb begin
		run_next = run_q;
		hit      = 1'b0;
		hit_bit  = '0;
		for (int j = 0; j < WB; j++) begin
			if (!hit) begin
				if (rd_data[j] || !inr[j]) begin
					run_next = '0;
				end else begin
					run_next = run_next + CNT_W'(1);
					if (run_next == need_q) begin
						hit     = 1'b1;
						hit_bit = LSB'(j);
					end
				end
			end
		end
	end

	assign end_idx    = {row_s1, hit_bit};
	assign start_full = {1'b0, end_idx} + (IDX_W + 1)'(1) - (IDX_W + 1)'(need_q);
	assign start_idx  = start_full[IDX_W-1:0];

	// set the run's bits in each row it covers
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			mark_wdata[j] = rd_data[j]
				| (((row_s1 != start_q[IDX_W-1:LSB]) || (LSB'(j) >= start_q[LSB-1:0]))
				&& ((row_s1 != end_q[IDX_W-1:LSB]) || (LSB'(j) <= end_q[LSB-1:0])));
		end
	end

	// clear used bits upward from the addressed block until a free one
	always_comb begin
		free_wdata = rd_data;
		free_go    = 1'b1;
		for (int j = 0; j < WB; j++) begin
			if (free_go && (!first_q || (LSB'(j) >= start_q[LSB-1:0]))) begin
				if (rd_data[j] && inr[j]) begin
					free_wdata[j] = 1'b0;
				end else begin
					free_go = 1'b0;
				end
			end
		end
		free_cont = free_go && (row_s1 != ROW_LAST);
	end

	always_comb begin
		wr_en   = cmd.clr_step || ((cmd.mark_step || cmd.free_step) && pv_s1);
		wr_addr = cmd.clr_step ? rd_row_q[ROW_W-1:0] : row_s1;
		if (cmd.clr_step) begin
			wr_data = '0;
		end else if (cmd.mark_step) begin
			wr_data = mark_wdata;
		end else begin
			wr_data = free_wdata;
		end
	end

	always_comb begin
		st.alloc_bad = bad_q || (quot > COUNT_OFF);
		st.free_bad  = bad_q;
		st.free_past = quot >= COUNT_OFF;
		st.found     = pv_s1 && hit;
		st.scan_end  = pv_s1 && !hit && (row_s1 == ROW_LAST);
		st.mark_last = pv_s1 && (row_s1 == end_q[IDX_W-1:LSB]);
		st.free_done = pv_s1 && !free_cont;
		st.clr_last  = rd_row_q[ROW_W-1:0] == ROW_LAST;
		st.out_busy  = out_valid_q && !out_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= ffba_pkg::HEAP_BASE_RESET;
			rd_row_q    <= '0;
			pv_s1       <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_base_q <= cfg_data;
			end
			if (cmd.cap || cmd.scan_start) begin
				rd_row_q <= '0;
				pv_s1    <= 1'b0;
			end else if (cmd.free_start) begin
				rd_row_q <= {1'b0, quot[IDX_W-1:LSB]};
				pv_s1    <= 1'b0;
				first_q  <= 1'b1;
			end else if (cmd.scan_step && pv_s1 && hit) begin
				// restart the walk at the first row of the run
				rd_row_q <= {1'b0, start_idx[IDX_W-1:LSB]};
				pv_s1    <= 1'b0;
			end else if (cmd.clr_step) begin
				rd_row_q <= rd_row_q + (ROW_W + 1)'(1);
			end else if (step_any) begin
				if (rd_issue) begin
					rd_row_q <= rd_row_q + (ROW_W + 1)'(1);
				end
				pv_s1 <= rd_issue;
				if (cmd.free_step && pv_s1) begin
					first_q <= 1'b0;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			if (func == ffba_pkg::FUNC_FREE) begin
				dividend_q <= free_off;
				bad_q      <= addr_bad;
			end else begin
				dividend_q <= alloc_div;
				bad_q      <= (req_bytes == 16'd0) || (bytes_ext > OFF_W'(HEAP_BYTES));
			end
		end
		if (cmd.mul) begin
			prod_q <= {RECIP_W'(0), dividend_q} * {OFF_W'(0), RECIP};
		end
		if (cmd.scan_start) begin
			need_q <= CNT_W'(quot);
			run_q  <= '0;
		end else if (cmd.scan_step && pv_s1 && !hit) begin
			run_q <= run_next;
		end
		if (cmd.free_start) begin
			start_q <= quot[IDX_W-1:0];
		end else if (cmd.scan_step && pv_s1 && hit) begin
			start_q <= start_idx;
			end_q   <= end_idx;
		end
		if (step_any) begin
			row_s1 <= rd_row_q[ROW_W-1:0];
		end
		if (cmd.calc) begin
			addr_prod_q <= 32'(start_q) * 32'(BLOCK_BYTES);
		end
		if (cmd.out_load) begin
			out_addr_q   <= (cmd.out_kind == ffba_pkg::OUT_GRANT)
				? heap_base_q + addr_prod_q : 32'd0;
			out_status_q <= cmd.out_kind == ffba_pkg::OUT_FAIL;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_status_q;

endmodule

`default_nettype wire

FILE: sv/first_fit_block_bitmap_allocator_top.sv
// First-fit block allocator: used-bit map of the heap in a small RAM, eight
// blocks per row, walked one row per cycle. After reset the block sweeps the
// map to zero, one row a cycle (HEAP_BYTES/BLOCK_BYTES/8 rows, 32 by default),
// and takes no request until that is done; configuration writes are taken
// throughout. A request moves over in_valid/in_ready and gives exactly one
// result on out_valid/out_ready. Allocate decodes, divides by the block size,
// scans map rows up to the row where a free run of the needed length ends,
// marks each row the run covers, then computes the address. A failed allocate
// answers after the size check or the full scan. Free decodes, divides, then
// clears used bits row by row from the addressed block. Clear sweeps every
// row. An unknown request kind answers straight after decode. One request is
// worked on at a time; the next one is taken while the previous result still
// waits in the output register. heap_base is written through cfg_valid/cfg_data,
// which is always ready; write it only while no request is in flight.
`default_nettype none

module first_fit_block_bitmap_allocator_top #(
	parameter int BLOCK_BYTES = 16,
	parameter int HEAP_BYTES  = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: heap base address
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] req_bytes,
	input  wire logic [31:0] free_address,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      granted_address,
	output logic             status
);

	ffba_pkg::cmd_t    cmd;
	ffba_pkg::status_t st;

	// the base register takes a write in any cycle
	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	ffba_dp #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.HEAP_BYTES  (HEAP_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid),
		.cfg_data        (cfg_data),
		.func            (func),
		.req_bytes       (req_bytes),
		.free_address    (free_address),
		.cmd             (cmd),
		.st              (st),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted_address (granted_address),
		.status          (status)
	);

	// a failed or ignored request never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> granted_address == 32'd0)
		else $error("failed result with nonzero address");

	// one request in flight: the channel closes right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !st.out_busy)
		else $error("result register loaded while occupied");

endmodule

`default_nettype wire

FILE: tb/sv/ffba_tb_pkg.sv
// Block map model and result store for the first-fit allocator testbench.
// Depends on ffba_pkg for the request kinds and the reset value of the heap base.
`timescale 1ns / 1ps

package ffba_tb_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int HEAP_BYTES  = 4096;
	localparam int N_BLOCKS    = HEAP_BYTES / BLOCK_BYTES;
	localparam int GRANT_KEEP  = 64;

	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam logic       STATUS_DONE  = 1'b0;
	localparam logic       STATUS_FAIL  = 1'b1;

	typedef struct packed {
		logic [31:0] addr;
		logic        status;
	} alloc_result_t;

	class alloc_scoreboard;
		bit            used_map [N_BLOCKS];
		logic [31:0]   heap_base;
		alloc_result_t pending [$];
		logic [31:0]   live_grants [$];
		int            fails;

		function new();
			heap_base = ffba_pkg::HEAP_BASE_RESET;
			foreach (used_map[i]) used_map[i] = 1'b0;
			fails = 0;
		endfunction

		function void set_base(logic [31:0] value);
			heap_base = value;
		endfunction

		// Update the block map for one accepted request and queue its answer.
		function void note_request(logic [1:0] kind, logic [15:0] bytes, logic [31:0] addr);
			alloc_result_t res;
			logic [32:0]   heap_top;
			int            need, run, k, m, idx;
			res.addr   = 32'd0;
			res.status = STATUS_FAIL;
			case (kind)
				ffba_pkg::FUNC_ALLOC: begin
					if (bytes != 16'd0 && bytes <= HEAP_BYTES) begin
						need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
						run  = 0;
						k    = 0;
						while (k < N_BLOCKS && res.status == STATUS_FAIL
								&& need <= N_BLOCKS) begin
							if (used_map[k]) begin
								run = 0;
							end else begin
								run++;
								if (run == need) begin
									for (m = k + 1 - need; m <= k; m++) used_map[m] = 1'b1;
									res.addr   = heap_base + 32'((k + 1 - need) * BLOCK_BYTES);
									res.status = STATUS_DONE;
								end
							end
							k++;
						end
					end
					if (res.status == STATUS_DONE) begin
						live_grants.push_back(res.addr);
						if (live_grants.size() > GRANT_KEEP) void'(live_grants.pop_front());
					end
				end
				ffba_pkg::FUNC_FREE: begin
					// heap end compared in 33 bits, so a heap at the top of memory does not wrap
					heap_top = {1'b0, heap_base} + 33'(HEAP_BYTES);
					if (addr != 32'd0 && addr >= heap_base && {1'b0, addr} < heap_top) begin
						idx = int'((addr - heap_base) / BLOCK_BYTES);
						while (idx < N_BLOCKS && used_map[idx]) begin
							used_map[idx] = 1'b0;
							idx++;
						end
						res.status = STATUS_DONE;
					end
				end
				ffba_pkg::FUNC_CLEAR: begin
					foreach (used_map[i]) used_map[i] = 1'b0;
					res.status = STATUS_DONE;
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		task report(string msg);
			fails++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic [31:0] addr, logic status);
			alloc_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with none pending: addr %h status %b", addr, status));
				return;
			end
			want = pending.pop_front();
			if (addr !== want.addr)
				report($sformatf("granted_address %h, want %h", addr, want.addr));
			if (status !== want.status)
				report($sformatf("status %b, want %b", status, want.status));
		endtask
	endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench of the first-fit block allocator: directed and random requests
// over several heap bases, checked against the block map model in ffba_tb_pkg.
// Depends on ffba_pkg, ffba_tb_pkg and first_fit_block_bitmap_allocator_top.
`timescale 1ns / 1ps

module tb_top;

	// margin over the longest correct request; allow the output stall on top
	localparam int SETTLE_CYCLES    = 100;
	// cycles with no handshake at all before the run is declared hung
	localparam int QUIET_LIMIT      = 2000;
	localparam int RANDOM_PER_PHASE = 260;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [15:0] req_bytes;
	logic [31:0] free_address;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] granted_address;
	logic        status;

	// chance in percent of an idle burst, drawn each cycle on the result side and after each accepted request
	int                           idle_pct = 0;
	int                           quiet    = 0;
	logic [31:0]                  cur_base = ffba_pkg::HEAP_BASE_RESET;
	ffba_tb_pkg::alloc_scoreboard sb       = new();

	first_fit_block_bitmap_allocator_top #(
		.BLOCK_BYTES(ffba_tb_pkg::BLOCK_BYTES),
		.HEAP_BYTES (ffba_tb_pkg::HEAP_BYTES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.req_bytes      (req_bytes),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_address(granted_address),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample every handshake at the edge. Check the result before noting a new
	// request, so an answer can never be matched against its own request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(granted_address, status);
			if (in_valid && in_ready)
				sb.note_request(func, req_bytes, free_address);
			if (cfg_valid && cfg_ready)
				sb.set_base(cfg_data);
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("first_fit_block_bitmap_allocator_top test failed");
				$finish;
			end
		end
	end

	// Result side: hold out_ready low in random bursts while idling is on.
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Present one request and hold it until accepted. Keep in_valid high into the
	// next request unless an idle burst is drawn.
	task automatic send_request(input logic [1:0] kind, input logic [15:0] bytes,
			input logic [31:0] addr);
		in_valid     <= 1'b1;
		func         <= kind;
		req_bytes    <= bytes;
		free_address <= addr;
		do @(posedge clk); while (!in_ready);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drop the request side, wait for every pending answer, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random request. Most frees target a live allocation so the map keeps
	// a mix of runs and holes; the rest are in-heap, null or arbitrary addresses.
	task automatic random_request();
		logic [1:0]  kind;
		logic [15:0] bytes;
		logic [31:0] addr;
		int          pick;
		int          idx;
		bytes = 16'($urandom);
		addr  = $urandom;
		pick  = $urandom_range(0, 99);
		if (pick < 58) begin
			kind = ffba_pkg::FUNC_ALLOC;
			case ($urandom_range(0, 19))
				0:          bytes = 16'd0;
				1:          bytes = 16'($urandom_range(ffba_tb_pkg::HEAP_BYTES + 1, 65535));
				2, 3, 4, 5: bytes = 16'($urandom_range(129, ffba_tb_pkg::HEAP_BYTES));
				default:    bytes = 16'($urandom_range(1, 128));
			endcase
		end else if (pick < 96) begin
			kind = ffba_pkg::FUNC_FREE;
			if (pick < 85 && sb.live_grants.size() != 0) begin
				idx  = $urandom_range(0, sb.live_grants.size() - 1);
				addr = sb.live_grants[idx];
				sb.live_grants.delete(idx);
				// sometimes point inside the first block rather than at its start
				if ($urandom_range(0, 3) == 0)
					addr = addr + 32'($urandom_range(0, ffba_tb_pkg::BLOCK_BYTES - 1));
			end else if (pick < 91) begin
				addr = cur_base + 32'($urandom_range(0, ffba_tb_pkg::HEAP_BYTES - 1));
			end else if (pick < 93) begin
				addr = 32'd0;
			end
		end else if (pick < 98) begin
			kind = ffba_pkg::FUNC_CLEAR;
		end else begin
			kind = ffba_tb_pkg::FUNC_UNKNOWN;
		end
		send_request(kind, bytes, addr);
	endtask

	// When rewrite is set, drain and set the heap base; then probe the heap edges and run random traffic.
	// In the final phase, each group of 64 requests that starts past the midpoint runs without idling.
	task automatic run_phase(input logic [31:0] base, input bit rewrite, input bit last);
		int i;
		if (rewrite) begin
			drain();
			write_base(base);
		end
		cur_base = base;
		send_request(ffba_pkg::FUNC_CLEAR, 16'd0, 32'd0);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, 32'd0);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, base - 32'd1);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, base);
		send_request(ffba_pkg::FUNC_ALLOC, 16'd16, 32'd0);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, base + 32'(ffba_tb_pkg::HEAP_BYTES - 1));
		send_request(ffba_pkg::FUNC_FREE, 16'd0, base + 32'(ffba_tb_pkg::HEAP_BYTES));
		send_request(ffba_pkg::FUNC_FREE, 16'd0, base);
		for (i = 0; i < RANDOM_PER_PHASE; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 15;
					default: idle_pct = 40;
				endcase
				if (last && i >= RANDOM_PER_PHASE / 2)
					idle_pct = 0;
			end
			random_request();
		end
	endtask

	initial begin
		logic [31:0] b;
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= 32'd0;
		in_valid     <= 1'b0;
		func         <= ffba_pkg::FUNC_ALLOC;
		req_bytes    <= 16'd0;
		free_address <= 32'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset heap base, fresh map after the clearing sweep.
		b = ffba_pkg::HEAP_BASE_RESET;
		idle_pct = 20;
		send_request(ffba_pkg::FUNC_ALLOC, 16'd0, 32'd0);       // zero bytes fails
		send_request(ffba_pkg::FUNC_ALLOC, 16'd1, 32'd0);       // block 0
		send_request(ffba_pkg::FUNC_ALLOC, 16'd16, 32'd0);      // block 1
		send_request(ffba_pkg::FUNC_ALLOC, 16'd17, 32'd0);      // blocks 2..3
		send_request(ffba_pkg::FUNC_ALLOC, 16'd4096, 32'd0);    // no free run left
		send_request(ffba_pkg::FUNC_ALLOC, 16'd4097, 32'd0);    // larger than the heap
		send_request(ffba_pkg::FUNC_ALLOC, 16'hFFFF, 32'd0);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, 32'd0);        // null address
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b - 32'd1);    // just below the heap
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b + 32'd4096); // just past the heap
		// mid-block address; clearing runs on into the following allocation
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b + 32'd21);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b + 32'd16);   // block already free
		send_request(ffba_tb_pkg::FUNC_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(ffba_pkg::FUNC_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(ffba_pkg::FUNC_ALLOC, 16'd4096, 32'd0);    // whole heap
		send_request(ffba_pkg::FUNC_ALLOC, 16'd1, 32'd0);       // full map fails
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b + 32'd4095); // last block only
		send_request(ffba_pkg::FUNC_ALLOC, 16'd16, 32'd0);      // lands on last block
		send_request(ffba_pkg::FUNC_FREE, 16'd0, b);            // runs to the heap end
		send_request(ffba_pkg::FUNC_ALLOC, 16'd4080, 32'd0);
		send_request(ffba_pkg::FUNC_FREE, 16'd0, 32'hFFFF_FFFF);
		send_request(ffba_pkg::FUNC_CLEAR, 16'd0, 32'd0);

		// Random phases over several heap bases, the extremes among them.
		run_phase(ffba_pkg::HEAP_BASE_RESET, 1'b0, 1'b0);
		run_phase(32'h0000_0000, 1'b1, 1'b0);
		run_phase(32'hFFFF_FFFF, 1'b1, 1'b0);
		run_phase(32'hFFFF_F800, 1'b1, 1'b0);   // heap wraps past the top of memory
		run_phase($urandom, 1'b1, 1'b0);
		run_phase(ffba_pkg::HEAP_BASE_RESET, 1'b1, 1'b1);

		drain();
		if (sb.fails == 0)
			$display("first_fit_block_bitmap_allocator_top test passed");
		else
			$display("first_fit_block_bitmap_allocator_top test failed");
		$finish;
	end

endmodule
